@@ hdl/thu_pkg.sv @@
// shared constants, codes and slot layout for the typed handle table
`default_nettype none

package thu_pkg;

    localparam int ENTRIES_DEF = 2048;

    localparam int ACTION_W = 2;
    localparam int TYPE_W   = 16;
    localparam int OBJ_W    = 32;
    localparam int HANDLE_W = 11;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [ACTION_W-1:0] ACT_NEW    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    // response codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] type_id;
        logic [OBJ_W-1:0]  object_ref;
        logic              is_free;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

`default_nettype wire

@@ hdl/thu_if.sv @@
// request and response channel interfaces of the typed handle table
`default_nettype none

interface thu_req_if
    import thu_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TYPE_W-1:0]   type_id;
    logic [OBJ_W-1:0]    object_ref;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, action, type_id, object_ref, handle, input ready);
    modport sink   (input valid, action, type_id, object_ref, handle, output ready);
endinterface

interface thu_rsp_if
    import thu_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [OBJ_W-1:0]    object_out;

    modport source (output valid, status, handle_out, object_out, input ready);
    modport sink   (input valid, status, handle_out, object_out, output ready);
endinterface

`default_nettype wire

@@ hdl/typed_handle_table_unit.sv @@
// typed handle table: allocate, look up and remove typed object handles
//
// i_req carries one request transaction (action, type_id, object_ref, handle);
// o_rsp returns exactly one response transaction (status, handle_out,
// object_out) per request, in request order. both use valid/ready.
// one request is worked at a time, all slot contents live in a single ram
// with one write port and one registered read port.
// lookup and remove pass through a read state, allocation of a fresh slot
// through an append state, before the result state; unknown actions go
// straight to it. allocation that reuses a freed slot walks the ram one
// entry per cycle from the free hint up to the freed slot; the single ram
// read port sets that walk rate. the next request can be taken in the cycle
// the response is offered. after reset the table is empty, the hint is
// marked absent and no ram clearing pass is needed, since a slot read at or
// above the high-water mark never counts as a hit. the response sits in an
// output register; a new request is accepted while it waits, but the next
// response is held until the receiver takes it, and no request is taken
// while a finished response waits to move to it.
`default_nettype none

module typed_handle_table_unit
    import thu_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    thu_req_if.sink    i_req,
    thu_rsp_if.source  o_rsp
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int CW   = IW + 1;
    localparam int CMPW = (CW > HANDLE_W) ? CW : HANDLE_W;
    localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    // control state
    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_used, n_used;          // high-water mark
    logic [CW-1:0]       r_free_cnt, n_free_cnt;  // freed slots below it
    logic [CW-1:0]       r_hint, n_hint;
    logic                r_hint_none, n_hint_none;
    logic [CW-1:0]       r_scan_addr, n_scan_addr;
    logic [IW-1:0]       r_chk_addr, n_chk_addr;
    logic                r_chk_valid, n_chk_valid;
    logic                r_out_valid, n_out_valid;

    // request held for the transaction in flight
    logic [ACTION_W-1:0] r_action, n_action;
    logic [TYPE_W-1:0]   r_type, n_type;
    logic [OBJ_W-1:0]    r_obj, n_obj;
    logic [HANDLE_W-1:0] r_handle, n_handle;

    // finished result and output register
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [OBJ_W-1:0]    r_res_obj, n_res_obj;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [OBJ_W-1:0]    r_out_obj, n_out_obj;

    // ram port
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    t_slot               ram_wdata;
    logic                ram_re;
    logic [IW-1:0]       ram_raddr;
    t_slot               rd_slot;

    // derived values
    logic [CMPW-1:0]     in_handle_ext;
    logic [CMPW-1:0]     r_handle_ext;
    logic [CMPW-1:0]     claim_ext;
    logic [CMPW-1:0]     append_ext;
    logic [IW-1:0]       h_idx;
    logic [IW-1:0]       append_idx;
    logic                hit;
    logic                scan_more;
    logic [CW-1:0]       hint_start;

    thu_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_slot)
    );

    assign in_handle_ext = CMPW'(i_req.handle);
    assign r_handle_ext  = CMPW'(r_handle);
    assign h_idx         = r_handle_ext[IW-1:0];
    assign append_idx    = r_used[IW-1:0];
    assign claim_ext     = CMPW'(r_chk_addr);
    assign append_ext    = CMPW'(append_idx);

    // handle must sit below the high-water mark, be in use and carry the type
    assign hit = (r_handle_ext < CMPW'(r_used)) && !rd_slot.is_free
                 && (rd_slot.type_id == r_type);

    assign scan_more  = (r_scan_addr < r_used);
    // a stale or missing hint restarts the scan at slot zero
    assign hint_start = (!r_hint_none && (r_hint < r_used)) ? r_hint : '0;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.handle_out = r_out_handle;
    assign o_rsp.object_out = r_out_obj;

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_free_cnt   = r_free_cnt;
        n_hint       = r_hint;
        n_hint_none  = r_hint_none;
        n_scan_addr  = r_scan_addr;
        n_chk_addr   = r_chk_addr;
        n_chk_valid  = r_chk_valid;
        n_action     = r_action;
        n_type       = r_type;
        n_obj        = r_obj;
        n_handle     = r_handle;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_obj    = r_res_obj;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_obj    = r_out_obj;
        n_out_valid  = r_out_valid && !o_rsp.ready;

        ram_we    = 1'b0;
        ram_waddr = append_idx;
        ram_wdata = '{type_id: r_type, object_ref: r_obj, is_free: 1'b0};
        ram_re    = 1'b0;
        ram_raddr = in_handle_ext[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action     = i_req.action;
                    n_type       = i_req.type_id;
                    n_obj        = i_req.object_ref;
                    n_handle     = i_req.handle;
                    n_res_status = ST_ABSENT;
                    n_res_handle = '0;
                    n_res_obj    = '0;
                    unique case (i_req.action)
                        ACT_NEW: begin
                            if (r_free_cnt != '0) begin
                                n_scan_addr = hint_start;
                                n_chk_valid = 1'b0;
                                n_state     = S_SCAN;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        ACT_GET, ACT_REMOVE: begin
                            ram_re  = 1'b1;
                            n_state = S_READ;
                        end
                        default: begin
                            // unknown action answers absent, changes nothing
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_READ: begin
                if (hit) begin
                    n_res_status = ST_OK;
                    if (r_action == ACT_GET) begin
                        n_res_obj = rd_slot.object_ref;
                    end else begin
                        // mark free, keep contents, lower the hint
                        ram_we     = 1'b1;
                        ram_waddr  = h_idx;
                        ram_wdata  = '{type_id: rd_slot.type_id,
                                       object_ref: rd_slot.object_ref,
                                       is_free: 1'b1};
                        n_free_cnt = r_free_cnt + CW'(1);
                        if (r_hint_none || (r_hint > CW'(h_idx))) begin
                            n_hint      = CW'(h_idx);
                            n_hint_none = 1'b0;
                        end
                    end
                end
                n_state = S_RESP;
            end

            S_SCAN: begin
                // read one entry per cycle, check the one read last cycle
                ram_re      = scan_more;
                ram_raddr   = r_scan_addr[IW-1:0];
                n_chk_valid = scan_more;
                n_chk_addr  = r_scan_addr[IW-1:0];
                if (scan_more) begin
                    n_scan_addr = r_scan_addr + CW'(1);
                end
                if (r_chk_valid && rd_slot.is_free) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_chk_addr;
                    n_free_cnt   = r_free_cnt - CW'(1);
                    if (r_free_cnt != CW'(1)) begin
                        n_hint      = CW'(r_chk_addr) + CW'(1);
                        n_hint_none = 1'b0;
                    end else begin
                        n_hint_none = 1'b1;
                    end
                    n_res_status = ST_OK;
                    n_res_handle = claim_ext[HANDLE_W-1:0];
                    n_chk_valid  = 1'b0;
                    n_state      = S_RESP;
                end else if (!r_chk_valid && !scan_more) begin
                    // nothing freed past the start, grow instead
                    n_state = S_APPEND;
                end
            end

            S_APPEND: begin
                if (r_used >= ENT_C) begin
                    n_res_status = ST_FULL;
                end else begin
                    ram_we       = 1'b1;
                    n_used       = r_used + CW'(1);
                    n_res_status = ST_OK;
                    n_res_handle = append_ext[HANDLE_W-1:0];
                end
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_out_obj    = r_res_obj;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_free_cnt  <= '0;
            r_hint      <= '1;
            r_hint_none <= 1'b1;
            r_scan_addr <= '0;
            r_chk_addr  <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_free_cnt  <= n_free_cnt;
            r_hint      <= n_hint;
            r_hint_none <= n_hint_none;
            r_scan_addr <= n_scan_addr;
            r_chk_addr  <= n_chk_addr;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_type       <= n_type;
        r_obj        <= n_obj;
        r_handle     <= n_handle;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_obj    <= n_res_obj;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_obj    <= n_out_obj;
    end

endmodule

`default_nettype wire

@@ hdl/thu_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
`default_nettype none

module thu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [AW-1:0]     i_waddr,
    input  wire [WIDTH-1:0]  i_wdata,
    input  wire              i_re,
    input  wire [AW-1:0]     i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
